// ===== rtl/core/swms_pkg.sv =====
// ----------------------------------------------------------------------------
// swms_pkg
// Shared types, field widths and width helpers for the sliding window
// mean / standard deviation block.
// ----------------------------------------------------------------------------
package swms_pkg;

  localparam int CH_FIELD_W  = 2;
  localparam int LEN_CFG_W   = 9;
  localparam int MEAN_W      = 24;
  localparam int SD_W        = 24;
  localparam int FILL_W      = 9;
  localparam int FRAC_BITS   = 8;
  localparam logic [LEN_CFG_W-1:0] LEN_RESET = 9'd16;

  // fill count / window length width
  function automatic int len_width(input int mw);
    return $clog2(mw + 1);
  endfunction

  // dividend width of the shared divider: (n*sumsq - sum^2) scaled by 2^16
  function automatic int div_width(input int mw, input int sb);
    return 2 * sb + 2 * len_width(mw) - 1 + 2 * FRAC_BITS;
  endfunction

  // root width for a radicand of div_width bits
  function automatic int root_width(input int mw, input int sb);
    return (div_width(mw, sb) + 1) / 2;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_MUL1,
    ST_MUL2,
    ST_DIFF,
    ST_DIV_MEAN,
    ST_MEAN,
    ST_DIV_VAR,
    ST_ROOT_LD,
    ST_ROOT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic upd;
    logic mul1;
    logic mul2;
    logic diff;
    logic div_step;
    logic mean_cap;
    logic root_load;
    logic root_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_sts_t;

endpackage

// ===== rtl/core/swms_if.sv =====
// ----------------------------------------------------------------------------
// swms channel interfaces
// Sample request channel, result channel and window length write channel.
// ----------------------------------------------------------------------------
interface swms_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                                    valid;
  logic                                    ready;
  logic [swms_pkg::CH_FIELD_W-1:0]         channel;
  logic signed [SAMPLE_BITS-1:0]           sample;

  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

interface swms_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [swms_pkg::CH_FIELD_W-1:0]         result_channel;
  logic signed [swms_pkg::MEAN_W-1:0]      mean_q;
  logic [swms_pkg::SD_W-1:0]               stddev_q;
  logic [swms_pkg::FILL_W-1:0]             fill_count;

  modport source (output valid, result_channel, mean_q, stddev_q, fill_count, input ready);
  modport sink   (input valid, result_channel, mean_q, stddev_q, fill_count, output ready);
endinterface

interface swms_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [swms_pkg::LEN_CFG_W-1:0]          data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/sliding_window_mean_stddev_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_mean_stddev_top
// Per-channel sliding window mean and population standard deviation.
// ----------------------------------------------------------------------------
//  port      dir   handshake      payload
//  samples   in    valid/ready    channel, sample
//  results   out   valid/ready    result_channel, mean_q, stddev_q, fill_count
//  cfg       in    valid/ready    data (window length, clears all windows)
//
//  one request at a time: after accept it runs through the window update,
//  the products, the bit-serial divider (mean, then variance) with
//  DV = 2*SAMPLE_BITS + 2*clog2(MAX_WINDOW+1) + 15 divider steps each,
//  and the root unit with RT = (DV+1)/2 root steps, then the result goes out.
//  a new request is taken while the previous result still waits.
//  rst is synchronous; cfg is always ready.
module sliding_window_mean_stddev_top #(
  parameter int CHANNELS    = 4,
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  swms_in_if.sink      samples,
  swms_out_if.source   results,
  swms_cfg_if.sink     cfg
);

  localparam int DIV_STEPS  = swms_pkg::div_width(MAX_WINDOW, SAMPLE_BITS);
  localparam int ROOT_STEPS = swms_pkg::root_width(MAX_WINDOW, SAMPLE_BITS);

  swms_pkg::dp_cmd_t cmd;
  swms_pkg::dp_sts_t sts;

  assign cfg.ready = 1'b1;

  swms_ctrl #(
    .DIV_STEPS  (DIV_STEPS),
    .ROOT_STEPS (ROOT_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  swms_datapath #(
    .CHANNELS    (CHANNELS),
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_channel  (samples.channel),
    .in_sample   (samples.sample),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.data),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_channel (results.result_channel),
    .out_mean    (results.mean_q),
    .out_stddev  (results.stddev_q),
    .out_fill    (results.fill_count),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== rtl/core/swms_ram.sv =====
// ----------------------------------------------------------------------------
// swms_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module swms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/swms_ctrl.sv =====
// ----------------------------------------------------------------------------
// swms_ctrl
// Sequencer: steps one request through window update, products, two
// divisions and the square root, then hands the result to the output stage.
// ----------------------------------------------------------------------------
module swms_ctrl #(
  parameter int DIV_STEPS  = 65,
  parameter int ROOT_STEPS = 33
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output swms_pkg::dp_cmd_t cmd,
  input  swms_pkg::dp_sts_t sts
);

  localparam int CW = $clog2(DIV_STEPS + 1);

  swms_pkg::state_t state, state_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic             div_last, root_last;

  assign div_last  = (cnt == CW'(DIV_STEPS - 1));
  assign root_last = (cnt == CW'(ROOT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swms_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = '0;
    unique case (state)
      swms_pkg::ST_IDLE:     if (in_valid) state_next = swms_pkg::ST_READ;
      swms_pkg::ST_READ:     state_next = swms_pkg::ST_UPDATE;
      swms_pkg::ST_UPDATE:   state_next = swms_pkg::ST_MUL1;
      swms_pkg::ST_MUL1:     state_next = swms_pkg::ST_MUL2;
      swms_pkg::ST_MUL2:     state_next = swms_pkg::ST_DIFF;
      swms_pkg::ST_DIFF:     state_next = swms_pkg::ST_DIV_MEAN;
      swms_pkg::ST_DIV_MEAN: begin
        if (div_last) state_next = swms_pkg::ST_MEAN;
        else cnt_next = cnt + 1'b1;
      end
      swms_pkg::ST_MEAN:     state_next = swms_pkg::ST_DIV_VAR;
      swms_pkg::ST_DIV_VAR: begin
        if (div_last) state_next = swms_pkg::ST_ROOT_LD;
        else cnt_next = cnt + 1'b1;
      end
      swms_pkg::ST_ROOT_LD:  state_next = swms_pkg::ST_ROOT;
      swms_pkg::ST_ROOT: begin
        if (root_last) state_next = swms_pkg::ST_EMIT;
        else cnt_next = cnt + 1'b1;
      end
      swms_pkg::ST_EMIT:     if (!sts.out_full) state_next = swms_pkg::ST_IDLE;
      default:               state_next = swms_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      swms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      swms_pkg::ST_READ:     cmd.square    = 1'b1;
      swms_pkg::ST_UPDATE:   cmd.upd       = 1'b1;
      swms_pkg::ST_MUL1:     cmd.mul1      = 1'b1;
      swms_pkg::ST_MUL2:     cmd.mul2      = 1'b1;
      swms_pkg::ST_DIFF:     cmd.diff      = 1'b1;
      swms_pkg::ST_DIV_MEAN: cmd.div_step  = 1'b1;
      swms_pkg::ST_MEAN:     cmd.mean_cap  = 1'b1;
      swms_pkg::ST_DIV_VAR:  cmd.div_step  = 1'b1;
      swms_pkg::ST_ROOT_LD:  cmd.root_load = 1'b1;
      swms_pkg::ST_ROOT:     cmd.root_step = 1'b1;
      swms_pkg::ST_EMIT:     cmd.emit      = !sts.out_full;
      default:               cmd           = '0;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.out_full)
    else $error("result loaded over a pending one");

  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == swms_pkg::ST_DIV_MEAN || state == swms_pkg::ST_DIV_VAR)
      |-> cnt <= CW'(DIV_STEPS - 1))
    else $error("divider step count overrun");

  a_root_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == swms_pkg::ST_ROOT) |-> cnt <= CW'(ROOT_STEPS - 1))
    else $error("root step count overrun");

endmodule

// ===== rtl/core/swms_datapath.sv =====
// ----------------------------------------------------------------------------
// swms_datapath
// Per-channel ring store, running sums, shared bit-serial divider, digit
// by digit square root and the output register.
// ----------------------------------------------------------------------------
module swms_datapath #(
  parameter int CHANNELS    = 4,
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [swms_pkg::CH_FIELD_W-1:0]       in_channel,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  logic                                  cfg_we,
  input  logic [swms_pkg::LEN_CFG_W-1:0]        cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [swms_pkg::CH_FIELD_W-1:0]       out_channel,
  output logic signed [swms_pkg::MEAN_W-1:0]    out_mean,
  output logic [swms_pkg::SD_W-1:0]             out_stddev,
  output logic [swms_pkg::FILL_W-1:0]           out_fill,
  input  swms_pkg::dp_cmd_t                     cmd,
  output swms_pkg::dp_sts_t                     sts
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CWW   = swms_pkg::CH_FIELD_W + 1;
  localparam int LEN_W = swms_pkg::len_width(MAX_WINDOW);
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int AW    = $clog2(CHANNELS * MAX_WINDOW);
  localparam int S_W   = SAMPLE_BITS + LEN_W;
  localparam int P_W   = 2 * SAMPLE_BITS;
  localparam int SQ_W  = 2 * SAMPLE_BITS + LEN_W - 1;
  localparam int H     = (SQ_W + 1) / 2;
  localparam int D_W   = SQ_W + LEN_W;
  localparam int DV_W  = swms_pkg::div_width(MAX_WINDOW, SAMPLE_BITS);
  localparam int DS_W  = 2 * LEN_W;
  localparam int RT_W  = swms_pkg::root_width(MAX_WINDOW, SAMPLE_BITS);
  localparam int RD_W  = 2 * RT_W;
  localparam int FB    = swms_pkg::FRAC_BITS;

  // window length register and its clamped value
  logic [swms_pkg::LEN_CFG_W-1:0] win_len;
  logic [LEN_W-1:0]               len_eff;

  always_comb begin
    if (win_len == '0) len_eff = LEN_W'(1);
    else if (int'(win_len) > MAX_WINDOW) len_eff = LEN_W'(MAX_WINDOW);
    else len_eff = LEN_W'(win_len);
  end

  // per channel state
  logic signed [S_W-1:0] sum_r  [CHANNELS];
  logic [SQ_W-1:0]       sq_r   [CHANNELS];
  logic [LEN_W-1:0]      fill_r [CHANNELS];
  logic [PTR_W-1:0]      ptr_r  [CHANNELS];

  // current request
  logic [CH_W-1:0]               ch_q, ch_in;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic [P_W-1:0]                smp_sq;
  logic [CWW-1:0]                cw;

  always_comb begin
    cw = {1'b0, in_channel};
    for (int i = 0; i < 3; i++) begin
      if (int'(cw) >= CHANNELS) cw = cw - CWW'(CHANNELS);
    end
    ch_in = CH_W'(cw);
  end

  // ring store access
  logic                          full;
  logic [PTR_W-1:0]              rd_pos, wr_pos, ptr_new;
  logic [AW-1:0]                 base;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] old;
  logic signed [P_W-1:0]         old_p, smp_p;
  logic signed [S_W-1:0]         sum_new;
  logic [SQ_W-1:0]               sq_new;
  logic [LEN_W-1:0]              fill_new;

  assign full   = fill_r[ch_q] >= len_eff;
  assign rd_pos = ptr_r[ch_q];
  assign wr_pos = full ? rd_pos : PTR_W'(fill_r[ch_q]);
  assign base   = AW'(ch_q) * AW'(MAX_WINDOW);
  assign old    = ram_rdata;
  assign old_p  = old * old;
  assign smp_p  = smp_q * smp_q;

  swms_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (CHANNELS * MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (base + AW'(wr_pos)),
    .wdata (smp_q),
    .raddr (base + AW'(rd_pos)),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (full) begin
      sum_new  = sum_r[ch_q] - S_W'(old) + S_W'(smp_q);
      sq_new   = sq_r[ch_q] - SQ_W'($unsigned(old_p)) + SQ_W'(smp_sq);
      fill_new = fill_r[ch_q];
      ptr_new  = (LEN_W'(rd_pos) + 1'b1 == len_eff) ? '0 : rd_pos + 1'b1;
    end else begin
      sum_new  = sum_r[ch_q] + S_W'(smp_q);
      sq_new   = sq_r[ch_q] + SQ_W'(smp_sq);
      fill_new = fill_r[ch_q] + 1'b1;
      ptr_new  = rd_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= swms_pkg::LEN_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]  <= '0;
        sq_r[i]   <= '0;
        fill_r[i] <= '0;
        ptr_r[i]  <= '0;
      end
    end else if (cfg_we) begin
      win_len <= cfg_data;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]  <= '0;
        sq_r[i]   <= '0;
        fill_r[i] <= '0;
        ptr_r[i]  <= '0;
      end
    end else if (cmd.upd) begin
      sum_r[ch_q]  <= sum_new;
      sq_r[ch_q]   <= sq_new;
      fill_r[ch_q] <= fill_new;
      ptr_r[ch_q]  <= ptr_new;
    end
  end

  // working copies and products
  logic [LEN_W-1:0]          wn;
  logic signed [S_W-1:0]     wsum;
  logic [SQ_W-1:0]           wsq;
  logic [LEN_W+H-1:0]        plo;
  logic [LEN_W+SQ_W-H-1:0]   phi;
  logic signed [2*S_W-1:0]   sum2;
  logic [DS_W-1:0]           nsq;
  logic [D_W-1:0]            dvar, prod;
  logic [S_W-1:0]            mag;
  logic                      neg_q;

  assign prod = (D_W'(phi) << H) + D_W'(plo);
  assign mag  = wsum[S_W-1] ? S_W'(-wsum) : S_W'(wsum);

  // shared restoring divider
  logic [DV_W-1:0] div_num, qa, qn;
  logic [DS_W-1:0] div_den, div_rem;
  logic [DS_W:0]   rem_sh;
  logic            div_ge;

  assign rem_sh = {div_rem, div_num[DV_W-1]};
  assign div_ge = rem_sh >= {1'b0, div_den};
  assign qa     = div_num + DV_W'(neg_q && div_rem != '0);
  assign qn     = neg_q ? (~qa + DV_W'(1)) : qa;

  // square root, two radicand bits per step
  logic [RD_W-1:0]   sq_x;
  logic [RT_W+1:0]   sq_rem;
  logic [RT_W-1:0]   root;
  logic [RT_W+3:0]   sr_sh, sr_trial;
  logic              sr_ge;

  assign sr_sh    = {sq_rem, sq_x[RD_W-1 -: 2]};
  assign sr_trial = (RT_W+4)'({root, 2'b01});
  assign sr_ge    = sr_sh >= sr_trial;

  logic [swms_pkg::MEAN_W-1:0] mean_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_q  <= ch_in;
      smp_q <= in_sample;
    end
    if (cmd.square) smp_sq <= $unsigned(smp_p);
    if (cmd.upd) begin
      wn   <= fill_new;
      wsum <= sum_new;
      wsq  <= sq_new;
    end
    if (cmd.mul1) begin
      plo  <= wn * wsq[H-1:0];
      sum2 <= wsum * wsum;
    end
    if (cmd.mul2) begin
      phi <= wn * wsq[SQ_W-1:H];
      nsq <= wn * wn;
    end
    if (cmd.diff) begin
      dvar    <= (prod >= D_W'($unsigned(sum2))) ? prod - D_W'($unsigned(sum2)) : '0;
      neg_q   <= wsum[S_W-1];
      div_num <= DV_W'({mag, {FB{1'b0}}});
      div_den <= DS_W'(wn);
      div_rem <= '0;
    end
    if (cmd.div_step) begin
      div_rem <= div_ge ? DS_W'(rem_sh - {1'b0, div_den}) : DS_W'(rem_sh);
      div_num <= {div_num[DV_W-2:0], div_ge};
    end
    if (cmd.mean_cap) begin
      mean_r  <= swms_pkg::MEAN_W'(qn);
      div_num <= DV_W'({dvar, {(2*FB){1'b0}}});
      div_den <= nsq;
      div_rem <= '0;
    end
    if (cmd.root_load) begin
      sq_x   <= RD_W'(div_num);
      sq_rem <= '0;
      root   <= '0;
    end
    if (cmd.root_step) begin
      sq_rem <= sr_ge ? (RT_W+2)'(sr_sh - sr_trial) : (RT_W+2)'(sr_sh);
      root   <= {root[RT_W-2:0], sr_ge};
      sq_x   <= sq_x << 2;
    end
    if (cmd.emit) begin
      out_channel <= swms_pkg::CH_FIELD_W'(ch_q);
      out_mean    <= mean_r;
      out_stddev  <= swms_pkg::SD_W'(root);
      out_fill    <= swms_pkg::FILL_W'(wn);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_full = out_valid;

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    cmd.upd && !cfg_we |=> (wn != '0 && wn <= len_eff))
    else $error("fill count out of range after update");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> div_rem < div_den)
    else $error("divider remainder not below divisor");

  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.root_step |=> sq_rem <= (RT_W+2)'({root, 1'b0}))
    else $error("root remainder exceeds twice the root");

endmodule
